// File: rtl/rtpp_pkg.sv
// ---------------------------------------------------------------------------
// rtpp_pkg: shared definitions for the packed pixel converter
// format codes, register indexes, byte counts and channel scaling tables
// ---------------------------------------------------------------------------
package rtpp_pkg;

  // output format codes
  localparam logic [2:0] FMT_RGB565   = 3'd0;
  localparam logic [2:0] FMT_BGR888   = 3'd1;
  localparam logic [2:0] FMT_ARGB4444 = 3'd2;
  localparam logic [2:0] FMT_ARGB1555 = 3'd3;
  localparam logic [2:0] FMT_BGRA8888 = 3'd4;

  // configuration register indexes
  localparam logic REG_PIXEL_FORMAT    = 1'b0;
  localparam logic REG_INPUT_HAS_ALPHA = 1'b1;

  // byte counts
  localparam logic [2:0] BYTES_2 = 3'd2;
  localparam logic [2:0] BYTES_3 = 3'd3;
  localparam logic [2:0] BYTES_4 = 3'd4;

  // scaling ratios, exact integer forms of v/8.2258, v/4.047619 and v/17
  localparam int Scale5Num = 10000;
  localparam int Scale5Den = 82258;
  localparam int Scale6Num = 1000000;
  localparam int Scale6Den = 4047619;
  localparam int Scale4Den = 17;

  typedef logic [255:0][3:0] lut4_t;
  typedef logic [255:0][4:0] lut5_t;
  typedef logic [255:0][5:0] lut6_t;

  function automatic lut4_t build_to4();
    lut4_t t;
    for (int i = 0; i < 256; i++) begin
      t[i] = 4'(i / Scale4Den);
    end
    return t;
  endfunction

  function automatic lut5_t build_to5();
    lut5_t t;
    for (int i = 0; i < 256; i++) begin
      t[i] = 5'((i * Scale5Num) / Scale5Den);
    end
    return t;
  endfunction

  function automatic lut6_t build_to6();
    lut6_t t;
    for (int i = 0; i < 256; i++) begin
      t[i] = 6'((i * Scale6Num) / Scale6Den);
    end
    return t;
  endfunction

  localparam lut4_t To4Lut = build_to4();
  localparam lut5_t To5Lut = build_to5();
  localparam lut6_t To6Lut = build_to6();

endpackage

// File: rtl/rgb_to_packed_pixel_converter.sv
// ---------------------------------------------------------------------------
// rgb_to_packed_pixel_converter
// packs an 8-bit rgba pixel into rgb565, bgr888, argb4444, argb1555 or
// bgra8888 as a little-endian word with its byte count
// ---------------------------------------------------------------------------
//
//  channel   direction  handshake               payload
//  -------   ---------  ----------------------  ---------------------------------
//  cfg       in         cfg_valid_i/cfg_ready_o cfg_index_i, cfg_data_i
//  in        in         in_valid_i/in_ready_o   red_i, green_i, blue_i, alpha_i
//  out       out        out_valid_o/out_ready_i pixel_word_o, byte_count_o
//
//  one pixel transfer per cycle while the output is not stalled; a pixel
//  passes through the input register, table lookup and packing mux, and
//  the result register
//  reset clears the valid flags and loads pixel_format 0, input_has_alpha 1
//  a stalled output holds its result while the input register still takes
//  one more pixel; cfg writes are always ready and take effect at once
//
module rgb_to_packed_pixel_converter
  import rtpp_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration writes
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_index_i,
  input  logic [2:0]  cfg_data_i,
  // pixel input
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  red_i,
  input  logic [7:0]  green_i,
  input  logic [7:0]  blue_i,
  input  logic [7:0]  alpha_i,
  // packed result
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] pixel_word_o,
  output logic [2:0]  byte_count_o
);

  // configuration registers
  logic [2:0] pixel_format_q;
  logic       has_alpha_q;

  // input stage
  logic       s1_valid_q;
  logic [7:0] red_q, green_q, blue_q, alpha_q;

  // result stage
  logic        out_valid_q;
  logic [31:0] word_q, word_d;
  logic [2:0]  count_q, count_d;

  logic s2_ready;
  logic s1_advance;
  logic [7:0] alpha_eff;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pixel_format_q <= FMT_RGB565;
      has_alpha_q    <= 1'b1;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_PIXEL_FORMAT:    pixel_format_q <= cfg_data_i;
        REG_INPUT_HAS_ALPHA: has_alpha_q    <= cfg_data_i[0];
        default:             ;
      endcase
    end
  end

  // result register frees up when empty or when its transfer completes
  assign s2_ready   = !out_valid_q || out_ready_i;
  assign s1_advance = s1_valid_q && s2_ready;
  assign in_ready_o = !s1_valid_q || s2_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      red_q   <= red_i;
      green_q <= green_i;
      blue_q  <= blue_i;
      alpha_q <= alpha_i;
    end
  end

  // missing alpha reads as fully opaque
  assign alpha_eff = has_alpha_q ? alpha_q : 8'hFF;

  always_comb begin
    word_d  = '0;
    count_d = BYTES_2;
    unique case (pixel_format_q)
      FMT_BGR888: begin
        word_d  = {8'h00, red_q, green_q, blue_q};
        count_d = BYTES_3;
      end
      FMT_ARGB4444: begin
        word_d  = {16'h0000, To4Lut[alpha_eff], To4Lut[red_q],
                   To4Lut[green_q], To4Lut[blue_q]};
        count_d = BYTES_2;
      end
      FMT_ARGB1555: begin
        word_d  = {16'h0000, (alpha_eff != 8'h00), To5Lut[red_q],
                   To5Lut[green_q], To5Lut[blue_q]};
        count_d = BYTES_2;
      end
      FMT_BGRA8888: begin
        word_d  = {alpha_eff, red_q, green_q, blue_q};
        count_d = BYTES_4;
      end
      default: begin
        // rgb565, also for the unused format codes
        word_d  = {16'h0000, To5Lut[red_q], To6Lut[green_q], To5Lut[blue_q]};
        count_d = BYTES_2;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s2_ready) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_advance) begin
      word_q  <= word_d;
      count_q <= count_d;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign pixel_word_o = word_q;
  assign byte_count_o = count_q;

  // a result always carries two to four bytes
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (count_q == BYTES_2 || count_q == BYTES_3 || count_q == BYTES_4))
    else $error("byte count out of range");

  // bytes past the count are zero
  a_upper_zero_2: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && count_q == BYTES_2) |-> (word_q[31:16] == 16'h0000))
    else $error("nonzero bytes beyond a two byte result");

  a_upper_zero_3: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && count_q == BYTES_3) |-> (word_q[31:24] == 8'h00))
    else $error("nonzero byte beyond a three byte result");

  // input only stalls when both stages are full
  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (s1_valid_q && out_valid_q))
    else $error("input stalled with a free stage");

  // a held input stage keeps its pixel
  a_s1_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && !s2_ready) |=> (s1_valid_q && $stable(red_q) && $stable(blue_q)))
    else $error("input stage changed while stalled");

endmodule
